>>> sv/line_follower_drive_controller_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef LINE_FOLLOWER_DRIVE_CONTROLLER_UNIT_DEFINES_SVH
`define LINE_FOLLOWER_DRIVE_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, switched off while reset is low
`define LFDC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("lfdc assertion failed: same-cycle implication");

// Next-cycle implication, switched off while reset is low
`define LFDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("lfdc assertion failed: next-cycle implication");

`endif

>>> sv/lfdc_pkg.sv
`timescale 1ns / 1ps

package lfdc_pkg;

  // Field widths
  localparam int KindW    = 1;
  localparam int CmdW     = 8;
  localparam int LineW    = 5;
  localparam int DistW    = 10;
  localparam int BridgeW  = 4;
  localparam int SpeedW   = 7;
  localparam int StepW    = 7;
  localparam int TicksW   = 8;
  localparam int PeriodW  = 17;
  localparam int DutyW    = 17;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 17;
  localparam int TurnW    = 2;
  localparam int ProdW    = PeriodW + SpeedW;

  localparam int TimerBitsDef = 8;

  // Item kinds
  localparam logic [KindW-1:0] KindTick = 1'b0;
  localparam logic [KindW-1:0] KindCmd  = 1'b1;

  // Menu command bytes
  localparam logic [CmdW-1:0] CmdSpeedUp   = 8'h4D; // M
  localparam logic [CmdW-1:0] CmdSpeedDown = 8'h4E; // N
  localparam logic [CmdW-1:0] CmdForward   = 8'h47; // G
  localparam logic [CmdW-1:0] CmdBack      = 8'h54; // T
  localparam logic [CmdW-1:0] CmdLeft      = 8'h4C; // L
  localparam logic [CmdW-1:0] CmdRight     = 8'h50; // P
  localparam logic [CmdW-1:0] CmdStop      = 8'h53; // S
  localparam logic [CmdW-1:0] CmdAutoOn    = 8'h41; // A
  localparam logic [CmdW-1:0] CmdAutoOff   = 8'h61; // a
  localparam logic [CmdW-1:0] CmdReport    = 8'h4F; // O

  // H-bridge line patterns
  localparam logic [BridgeW-1:0] BrOff   = 4'd0;
  localparam logic [BridgeW-1:0] BrFwd   = 4'd5;
  localparam logic [BridgeW-1:0] BrBack  = 4'd10;
  localparam logic [BridgeW-1:0] BrLeft  = 4'd9;
  localparam logic [BridgeW-1:0] BrRight = 4'd6;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegThreshold = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStep      = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLimit     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegReverse   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTurn      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPeriod    = 3'd5;

  // Reset values
  localparam logic [DistW-1:0]   ThresholdRst = 10'd15;
  localparam logic [StepW-1:0]   StepRst      = 7'd10;
  localparam logic [SpeedW-1:0]  LimitRst     = 7'd100;
  localparam logic [TicksW-1:0]  ReverseRst   = 8'd30;
  localparam logic [TicksW-1:0]  TurnRst      = 8'd150;
  localparam logic [PeriodW-1:0] PeriodRst    = 17'd100;
  localparam logic [SpeedW-1:0]  SpeedRst     = 7'd10;

  localparam logic [SpeedW-1:0] SpeedMax = 7'd100;

  // Divide by 100: ceil(2^30 / 100), exact for every product below 2^30 / 76
  localparam int                RecipShift = 30;
  localparam logic [ProdW-1:0]  Recip100   = 24'd10737419;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [CmdW-1:0]  command;
    logic [LineW-1:0] line_bits;
    logic [DistW-1:0] left_distance_cm;
    logic [DistW-1:0] right_distance_cm;
  } item_t;

  typedef struct packed {
    logic [BridgeW-1:0] bridge_lines;
    logic [DutyW-1:0]   pwm_duty;
    logic               auto_active;
    logic [SpeedW-1:0]  speed_now;
    logic               report_request;
    logic               obstacle_stop;
  } result_t;

endpackage

>>> sv/lfdc_stream_if.sv
`timescale 1ns / 1ps

interface lfdc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/line_follower_drive_controller_unit.sv
`timescale 1ns / 1ps
// Channel    Dir  Payload                                      Transfer
// item_i     in   kind, command, line_bits, left/right dist    valid & ready
// result_o   out  bridge_lines, pwm_duty, auto_active, ...     valid & ready
// cfg        in   cfg_we_i, cfg_idx_i, cfg_wdata_i              cfg_we_i high
//
// One item per cycle while result_o is not stalled; each result is registered in turn
// through these stages before it is valid on result_o
// (state update, period x speed product, reciprocal multiply for /100).
// Drive state updates at the item transfer, so the next item sees it at once.
// Asynchronous active-low reset; no clearing pass, item_i ready as reset releases.
// A stalled result_o fills the pipeline bubbles first, then item_i ready drops.

module line_follower_drive_controller_unit #(
  parameter int TIMER_BITS = lfdc_pkg::TimerBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lfdc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lfdc_pkg::CfgDataW-1:0] cfg_wdata_i,
  lfdc_stream_if.sink                   item_i,
  lfdc_stream_if.source                 result_o
);
  import lfdc_pkg::*;

  // Recovery phase codes
  localparam logic [1:0] PhIdle    = 2'd0;
  localparam logic [1:0] PhReverse = 2'd1;
  localparam logic [1:0] PhTurn    = 2'd2;

  // Last turn codes
  localparam logic [TurnW-1:0] TurnStraight = 2'd0;
  localparam logic [TurnW-1:0] TurnLeft     = 2'd1;
  localparam logic [TurnW-1:0] TurnRight    = 2'd2;

  // Timer load saturation
  localparam int TcW = (TIMER_BITS > TicksW) ? TIMER_BITS : TicksW;
  localparam logic [TcW-1:0] TimerMax = TcW'((64'd1 << TIMER_BITS) - 64'd1);

  function automatic logic [TIMER_BITS-1:0] load_timer(input logic [TicksW-1:0] ticks);
    logic [TcW-1:0] wide;
    wide = TcW'(ticks);
    if (wide > TimerMax) wide = TimerMax;
    return wide[TIMER_BITS-1:0];
  endfunction

  typedef struct packed {
    logic [BridgeW-1:0] bridge;
    logic               auto_on;
    logic [SpeedW-1:0]  speed;
    logic               report;
    logic               obst;
    logic               dzero;
  } snap_t;

  // Configuration registers
  logic [DistW-1:0]   thr_q;
  logic [StepW-1:0]   step_q;
  logic [SpeedW-1:0]  limit_q;
  logic [TicksW-1:0]  rev_q;
  logic [TicksW-1:0]  turn_q;
  logic [PeriodW-1:0] period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= ThresholdRst;
      step_q   <= StepRst;
      limit_q  <= LimitRst;
      rev_q    <= ReverseRst;
      turn_q   <= TurnRst;
      period_q <= PeriodRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegThreshold: thr_q    <= cfg_wdata_i[DistW-1:0];
        RegStep:      step_q   <= cfg_wdata_i[StepW-1:0];
        RegLimit:     limit_q  <= cfg_wdata_i[SpeedW-1:0];
        RegReverse:   rev_q    <= cfg_wdata_i[TicksW-1:0];
        RegTurn:      turn_q   <= cfg_wdata_i[TicksW-1:0];
        RegPeriod:    period_q <= cfg_wdata_i[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  logic take;

  assign en3          = !v3_q || result_o.ready;
  assign en2          = !v2_q || en3;
  assign en1          = !v1_q || en2;
  assign item_i.ready = en1;
  assign take         = item_i.valid && en1;

  // Drive state; duty held as (zero flag, speed, period) and scaled downstream
  logic [SpeedW-1:0]     speed_q, speed_d;
  logic                  auto_q, auto_d;
  logic [TurnW-1:0]      last_q, last_d;
  logic [1:0]            phase_q, phase_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d;
  logic [BridgeW-1:0]    bridge_q, bridge_d;
  logic                  dzero_q, dzero_d;
  logic [SpeedW-1:0]     dspeed_q, dspeed_d;
  logic [PeriodW-1:0]    dper_q, dper_d;
  logic                  report, obst;

  logic [SpeedW:0]       sum;
  logic [SpeedW-1:0]     lim;
  logic [TIMER_BITS-1:0] tmr_dec;
  logic                  blocked;
  logic [BridgeW-1:0]    turn_lines;

  assign sum = {1'b0, speed_q} + {1'b0, step_q};
  assign lim = (limit_q > SpeedMax) ? SpeedMax : limit_q;
  assign tmr_dec = (timer_q != '0) ? timer_q - TIMER_BITS'(1) : timer_q;
  assign blocked = (item_i.data.left_distance_cm == '0) ||
                   (item_i.data.right_distance_cm == '0) ||
                   (item_i.data.left_distance_cm < thr_q) ||
                   (item_i.data.right_distance_cm < thr_q);
  assign turn_lines = (last_q == TurnLeft)  ? BrLeft :
                      (last_q == TurnRight) ? BrRight : BrFwd;

  always_comb begin
    speed_d  = speed_q;
    auto_d   = auto_q;
    last_d   = last_q;
    phase_d  = phase_q;
    timer_d  = timer_q;
    bridge_d = bridge_q;
    dzero_d  = dzero_q;
    dspeed_d = dspeed_q;
    dper_d   = dper_q;
    report   = 1'b0;
    obst     = 1'b0;
    if (take) begin
      if (item_i.data.kind == KindCmd) begin
        // Menu commands
        case (item_i.data.command)
          CmdSpeedUp: begin
            speed_d  = (sum <= {1'b0, lim}) ? sum[SpeedW-1:0] : lim;
            dzero_d  = 1'b0;
            dspeed_d = speed_d;
            dper_d   = period_q;
          end
          CmdSpeedDown: begin
            speed_d  = (speed_q >= step_q) ? speed_q - step_q : '0;
            dzero_d  = 1'b0;
            dspeed_d = speed_d;
            dper_d   = period_q;
          end
          CmdForward, CmdBack, CmdLeft, CmdRight: begin
            case (item_i.data.command)
              CmdForward: bridge_d = BrFwd;
              CmdBack:    bridge_d = BrBack;
              CmdLeft:    bridge_d = BrLeft;
              default:    bridge_d = BrRight;
            endcase
            dzero_d  = 1'b0;
            dspeed_d = speed_q;
            dper_d   = period_q;
          end
          CmdStop: begin
            bridge_d = BrOff;
            dzero_d  = 1'b1;
          end
          CmdAutoOn: auto_d = 1'b1;
          CmdAutoOff: begin
            auto_d   = 1'b0;
            phase_d  = PhIdle;
            timer_d  = '0;
            bridge_d = BrOff;
            dzero_d  = 1'b1;
          end
          CmdReport: report = 1'b1;
          default: ;
        endcase
      end else if (auto_q) begin
        if (phase_q == PhReverse || phase_q == PhTurn) begin
          // Timed recovery, sensors ignored
          timer_d = tmr_dec;
          if (tmr_dec == '0) begin
            if (phase_q == PhReverse) begin
              bridge_d = turn_lines;
              dzero_d  = 1'b0;
              dspeed_d = speed_q;
              dper_d   = period_q;
              phase_d  = PhTurn;
              timer_d  = load_timer(turn_q);
            end else begin
              dzero_d = 1'b1;
              phase_d = PhIdle;
            end
          end
        end else begin
          phase_d = PhIdle;
          if (blocked) begin
            bridge_d = BrOff;
            dzero_d  = 1'b1;
            obst     = 1'b1;
          end else begin
            // Line decode by priority: centre, left, right, leftmost, rightmost
            dzero_d  = 1'b0;
            dspeed_d = speed_q;
            dper_d   = period_q;
            if (item_i.data.line_bits[2]) begin
              bridge_d = BrFwd;
              last_d   = TurnStraight;
            end else if (item_i.data.line_bits[1] || item_i.data.line_bits[0] &&
                         !item_i.data.line_bits[3]) begin
              bridge_d = BrLeft;
              last_d   = TurnLeft;
            end else if (item_i.data.line_bits[3] || item_i.data.line_bits[4]) begin
              bridge_d = BrRight;
              last_d   = TurnRight;
            end else begin
              bridge_d = BrBack;
              phase_d  = PhReverse;
              timer_d  = load_timer(rev_q);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q  <= SpeedRst;
      auto_q   <= 1'b0;
      last_q   <= TurnStraight;
      phase_q  <= PhIdle;
      timer_q  <= '0;
      bridge_q <= BrOff;
      dzero_q  <= 1'b0;
      dspeed_q <= SpeedRst;
      dper_q   <= PeriodRst;
    end else begin
      speed_q  <= speed_d;
      auto_q   <= auto_d;
      last_q   <= last_d;
      phase_q  <= phase_d;
      timer_q  <= timer_d;
      bridge_q <= bridge_d;
      dzero_q  <= dzero_d;
      dspeed_q <= dspeed_d;
      dper_q   <= dper_d;
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= item_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Stage payloads
  snap_t              s1_q, s2_q;
  logic [SpeedW-1:0]  s1_dspeed_q;
  logic [PeriodW-1:0] s1_dper_q;
  logic [ProdW-1:0]   s2_prod_q;
  result_t            res_q;
  logic [2*ProdW-1:0] scaled;

  assign scaled = s2_prod_q * Recip100;

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_q.bridge  <= bridge_d;
      s1_q.auto_on <= auto_d;
      s1_q.speed   <= speed_d;
      s1_q.report  <= report;
      s1_q.obst    <= obst;
      s1_q.dzero   <= dzero_d;
      s1_dspeed_q  <= dspeed_d;
      s1_dper_q    <= dper_d;
    end
    // period x speed
    if (en2 && v1_q) begin
      s2_q      <= s1_q;
      s2_prod_q <= ProdW'(s1_dper_q) * ProdW'(s1_dspeed_q);
    end
    // divide by 100 through the reciprocal
    if (en3 && v2_q) begin
      res_q.bridge_lines   <= s2_q.bridge;
      res_q.pwm_duty       <= s2_q.dzero ? '0 : scaled[RecipShift+DutyW-1:RecipShift];
      res_q.auto_active    <= s2_q.auto_on;
      res_q.speed_now      <= s2_q.speed;
      res_q.report_request <= s2_q.report;
      res_q.obstacle_stop  <= s2_q.obst;
    end
  end

  assign result_o.valid = v3_q;
  assign result_o.data  = res_q;

endmodule

>>> sv/lfdc_checker.sv
`timescale 1ns / 1ps
`include "line_follower_drive_controller_unit_defines.svh"

module lfdc_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     res_valid,
  input logic                     res_ready,
  input lfdc_pkg::result_t        res_data
);
  import lfdc_pkg::*;

  logic res_stall;
  logic obst_seen;
  logic motors_off;
  logic bridge_known;

  assign res_stall  = res_valid && !res_ready;
  assign obst_seen  = res_valid && res_data.obstacle_stop;
  assign motors_off = (res_data.bridge_lines == BrOff) && (res_data.pwm_duty == '0) &&
                      res_data.auto_active && !res_data.report_request;
  assign bridge_known = (res_data.bridge_lines == BrOff) ||
                        (res_data.bridge_lines == BrFwd) ||
                        (res_data.bridge_lines == BrBack) ||
                        (res_data.bridge_lines == BrLeft) ||
                        (res_data.bridge_lines == BrRight);

  // A stalled result keeps its valid and its fields
  `LFDC_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_stall, res_valid && $stable(res_data))

  // An obstacle stop only comes from a tick in auto mode and leaves the motors off
  `LFDC_ASSERT_NOW(a_obst_off, clk_i, rst_ni, obst_seen, motors_off)

  // Speed never leaves its range
  `LFDC_ASSERT_NOW(a_speed_rng, clk_i, rst_ni, res_valid, res_data.speed_now <= SpeedMax)

  // Bridge lines only ever carry one of the five drive patterns
  `LFDC_ASSERT_NOW(a_bridge_code, clk_i, rst_ni, res_valid, bridge_known)

endmodule

bind line_follower_drive_controller_unit lfdc_checker u_lfdc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .res_valid (result_o.valid),
  .res_ready (result_o.ready),
  .res_data  (result_o.data)
);
